[hdl/assert_macros.svh]
// Assertion helpers for the gyro bias estimator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent check, disabled while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check that an event is followed by a condition in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/gsbe_pkg.sv]
`default_nettype none
package gsbe_pkg;

    localparam int SMP_W      = 16;
    localparam int THR_W      = 32;
    localparam int MIN_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_AXES   = 3;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    localparam logic [THR_W-1:0] NOISE_THR_RST  = 32'd1000;
    localparam logic [MIN_W-1:0] MIN_STATIC_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NOISE_THR  = 1'b0,
        CFG_MIN_STATIC = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_MUL,
        ST_ACC_ADD,
        ST_VAR_MUL,
        ST_VAR_ADD,
        ST_LIM,
        ST_CMP,
        ST_CHK,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

[hdl/gsbe_in_if.sv]
`default_nettype none
interface gsbe_in_if;
    import gsbe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] gyro_x;
    logic signed [SMP_W-1:0] gyro_y;
    logic signed [SMP_W-1:0] gyro_z;
    logic signed [SMP_W-1:0] accel_x;
    logic signed [SMP_W-1:0] accel_y;
    logic signed [SMP_W-1:0] accel_z;

    modport source (
        output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
        input  ready
    );
    modport sink (
        input  valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
        output ready
    );
endinterface
`default_nettype wire

[hdl/gsbe_out_if.sv]
`default_nettype none
interface gsbe_out_if;
    import gsbe_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    bias_valid;
    logic signed [SMP_W-1:0] bias_x;
    logic signed [SMP_W-1:0] bias_y;
    logic signed [SMP_W-1:0] bias_z;

    modport source (
        output valid, bias_valid, bias_x, bias_y, bias_z,
        input  ready
    );
    modport sink (
        input  valid, bias_valid, bias_x, bias_y, bias_z,
        output ready
    );
endinterface
`default_nettype wire

[hdl/gsbe_div.sv]
`default_nettype none
// Radix-2 restoring divider, one quotient bit per cycle.
// Requires i_dividend < i_divisor * 2**QW.
module gsbe_div #(
    parameter int NW = 17,
    parameter int QW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NW+QW-1:0] i_dividend,
    input  logic [NW-1:0]    i_divisor,
    output logic             o_done,
    output logic [QW-1:0]    o_quot
);
    localparam int CW = $clog2(QW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_rem;
    logic [QW-1:0] r_q;

    logic [NW:0] trial;
    logic [NW:0] diff;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_q[QW-1]};
        diff  = trial - {1'b0, i_divisor};
        ge    = (trial >= {1'b0, i_divisor});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Low dividend bits shift out at the top while quotient bits enter below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[NW+QW-1:QW];
            r_q   <= i_dividend[QW-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? diff[NW-1:0] : trial[NW-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

[hdl/gyro_static_bias_estimator.sv]
`default_nettype none
`include "assert_macros.svh"
// Gyro static bias estimator. Takes one gyro/accel sample per request and returns exactly one
// result per request; bias_valid marks results that close a static interval longer than
// min_static_samples, and the bias fields are zero otherwise. Samples are grouped into windows
// of WINDOW_LEN; at each window end the accel variance sum is tested against noise_threshold.
// One sample is worked at a time through a single shared squarer, one axis after another, so
// a new sample is taken only once the last one is through. A window end adds the variance
// test, and a window that yields a bias adds the serial divider for each axis in turn (one
// quotient bit per cycle). The finished result sits in an output register, so the next
// sample is taken while it waits; a second result holds the block in its last step until
// the first one is taken. Configuration writes take effect at once and must be made while no
// sample is in flight.
module gyro_static_bias_estimator #(
    parameter int WINDOW_LEN = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [gsbe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gsbe_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gsbe_in_if.sink                         i_sample,
    gsbe_out_if.source                      o_bias
);
    import gsbe_pkg::*;

    localparam int LW      = $clog2(WINDOW_LEN);
    localparam int SUM_W   = SMP_W + LW;
    localparam int MAG_W   = SUM_W;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int SQS_W   = 2 * SMP_W - 1 + LW;
    localparam int WQ_W    = SQS_W + LW;
    localparam int SPR_W   = WQ_W + 2;
    localparam int LIM_W   = THR_W + 2 * LW;
    localparam int CNT_W   = $clog2((1 << MIN_W) + WINDOW_LEN);
    localparam int QUO_W   = SMP_W;
    localparam int DIVD_W  = CNT_W + QUO_W;
    localparam int ISUM_W  = DIVD_W + 1;

    localparam logic [WQ_W-1:0]  WLEN_WQ  = WQ_W'(WINDOW_LEN);
    localparam logic [LIM_W-1:0] WSQ_LIM  = LIM_W'(WINDOW_LEN * WINDOW_LEN);
    localparam logic [LW-1:0]    WPOS_END = LW'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] WLEN_CNT = CNT_W'(WINDOW_LEN);

    t_state r_state;
    t_state n_state;

    logic [1:0]              r_k;
    logic signed [SMP_W-1:0] r_gyro [NUM_AXES];
    logic signed [SMP_W-1:0] r_acc  [NUM_AXES];

    logic [LW-1:0]            r_wpos;
    logic signed [SUM_W-1:0]  r_asum [NUM_AXES];
    logic signed [SUM_W-1:0]  r_gsum [NUM_AXES];
    logic [SQS_W-1:0]         r_asq  [NUM_AXES];
    logic signed [ISUM_W-1:0] r_isum [NUM_AXES];
    logic [CNT_W-1:0]         r_icount;

    logic [THR_W-1:0] r_thr;
    logic [MIN_W-1:0] r_min;

    logic [SMP_W-1:0]  acc_mag;
    logic [MAG_W-1:0]  sum_mag;
    logic [MAG_W-1:0]  sq_op;
    logic [PROD_W-1:0] r_prod;
    logic [WQ_W-1:0]   r_wq;
    logic [SPR_W-1:0]  r_spread;
    logic [LIM_W-1:0]  r_lim;

    logic [DIVD_W-1:0] div_mag;
    logic [QUO_W-1:0]  w_quot;
    logic              w_div_done;

    logic                    r_res_valid;
    logic signed [SMP_W-1:0] r_bias  [NUM_AXES];
    logic                    r_ovalid;
    logic                    r_obv;
    logic signed [SMP_W-1:0] r_obias [NUM_AXES];

    logic accept;
    logic axis_last;
    logic window_end;
    logic quiet;
    logic long_enough;
    logic slot_free;
    logic out_zero;

    logic in_ready;
    logic use_sum;
    logic div_start;
    logic load_out;

    assign accept      = i_sample.valid && i_sample.ready;
    assign axis_last   = (r_k == AXIS_LAST);
    assign window_end  = (r_wpos == WPOS_END);
    assign quiet       = (r_spread < SPR_W'(r_lim));
    assign long_enough = (r_icount > CNT_W'(r_min));
    assign slot_free   = !r_ovalid || o_bias.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (accept) n_state = ST_ACC_MUL;
            ST_ACC_MUL:  n_state = ST_ACC_ADD;
            ST_ACC_ADD: begin
                if (!axis_last) begin
                    n_state = ST_ACC_MUL;
                end else if (window_end) begin
                    n_state = ST_VAR_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_VAR_MUL:  n_state = ST_VAR_ADD;
            ST_VAR_ADD:  n_state = axis_last ? ST_LIM : ST_VAR_MUL;
            ST_LIM:      n_state = ST_CMP;
            ST_CMP:      n_state = quiet ? ST_CHK : ST_DONE;
            ST_CHK:      n_state = long_enough ? ST_DIV_GO : ST_DONE;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = axis_last ? ST_DONE : ST_DIV_GO;
                end
            end
            ST_DONE:     if (slot_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control decode
    always_comb begin
        in_ready  = 1'b0;
        use_sum   = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            ST_IDLE:    in_ready  = 1'b1;
            ST_VAR_MUL: use_sum   = 1'b1;
            ST_DIV_GO:  div_start = 1'b1;
            ST_DONE:    load_out  = slot_free;
            default: ;
        endcase
    end

    assign i_sample.ready = in_ready;

    // Shared squarer operand: accel magnitude per sample, accel sum magnitude per window.
    always_comb begin
        acc_mag = r_acc[r_k][SMP_W-1] ? SMP_W'(-r_acc[r_k]) : SMP_W'(r_acc[r_k]);
        sum_mag = r_asum[r_k][SUM_W-1] ? MAG_W'(-r_asum[r_k]) : MAG_W'(r_asum[r_k]);
        sq_op   = use_sum ? sum_mag : MAG_W'(acc_mag);
        div_mag = r_isum[r_k][ISUM_W-1] ? DIVD_W'(-r_isum[r_k]) : DIVD_W'(r_isum[r_k]);
    end

    gsbe_div #(
        .NW (CNT_W),
        .QW (QUO_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_mag),
        .i_divisor  (r_icount),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_wpos      <= '0;
            r_icount    <= '0;
            r_thr       <= NOISE_THR_RST;
            r_min       <= MIN_STATIC_RST;
            r_ovalid    <= 1'b0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_asum[i] <= '0;
                r_gsum[i] <= '0;
                r_asq[i]  <= '0;
                r_isum[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_NOISE_THR:  r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_MIN_STATIC: r_min <= i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_bias.ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_k         <= '0;
                        r_res_valid <= 1'b0;
                    end
                end
                ST_ACC_ADD: begin
                    r_asq[r_k]  <= r_asq[r_k] + SQS_W'(r_prod);
                    r_asum[r_k] <= r_asum[r_k] + SUM_W'(r_acc[r_k]);
                    r_gsum[r_k] <= r_gsum[r_k] + SUM_W'(r_gyro[r_k]);
                    if (axis_last) begin
                        r_k <= '0;
                        if (!window_end) begin
                            r_wpos <= r_wpos + 1'b1;
                        end
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_VAR_ADD: begin
                    r_k <= axis_last ? 2'd0 : r_k + 1'b1;
                end
                ST_CMP: begin
                    // Close the window; a noisy window also drops the interval.
                    r_wpos <= '0;
                    for (int i = 0; i < NUM_AXES; i++) begin
                        r_asum[i] <= '0;
                        r_gsum[i] <= '0;
                        r_asq[i]  <= '0;
                        if (quiet) begin
                            r_isum[i] <= r_isum[i] + ISUM_W'(r_gsum[i]);
                        end else begin
                            r_isum[i] <= '0;
                        end
                    end
                    r_icount <= quiet ? r_icount + WLEN_CNT : '0;
                end
                ST_DIV_WAIT: begin
                    if (w_div_done) begin
                        if (axis_last) begin
                            r_k         <= '0;
                            r_res_valid <= 1'b1;
                            r_icount    <= '0;
                            for (int i = 0; i < NUM_AXES; i++) begin
                                r_isum[i] <= '0;
                            end
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(sq_op) * PROD_W'(sq_op);

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_gyro[0] <= i_sample.gyro_x;
                    r_gyro[1] <= i_sample.gyro_y;
                    r_gyro[2] <= i_sample.gyro_z;
                    r_acc[0]  <= i_sample.accel_x;
                    r_acc[1]  <= i_sample.accel_y;
                    r_acc[2]  <= i_sample.accel_z;
                    r_spread  <= '0;
                    for (int i = 0; i < NUM_AXES; i++) begin
                        r_bias[i] <= '0;
                    end
                end
            end
            ST_VAR_MUL: r_wq <= WQ_W'(r_asq[r_k]) * WLEN_WQ;
            // W*Q never falls below S*S, so the per-axis term stays non-negative.
            ST_VAR_ADD: r_spread <= r_spread + SPR_W'(r_wq) - SPR_W'(r_prod);
            ST_LIM:     r_lim <= LIM_W'(r_thr) * WSQ_LIM;
            ST_DIV_WAIT: begin
                if (w_div_done) begin
                    r_bias[r_k] <= r_isum[r_k][ISUM_W-1] ? $signed(QUO_W'(-w_quot))
                                                         : $signed(w_quot);
                end
            end
            default: ;
        endcase

        if (load_out) begin
            r_obv <= r_res_valid;
            for (int i = 0; i < NUM_AXES; i++) begin
                r_obias[i] <= r_bias[i];
            end
        end
    end

    assign o_bias.valid      = r_ovalid;
    assign o_bias.bias_valid = r_obv;
    assign o_bias.bias_x     = r_obias[0];
    assign o_bias.bias_y     = r_obias[1];
    assign o_bias.bias_z     = r_obias[2];

    assign out_zero = (o_bias.bias_x == '0) && (o_bias.bias_y == '0) && (o_bias.bias_z == '0);

    `ASSERT_RST(a_wpos_range, i_clk, i_rst_n, r_state == ST_IDLE |-> 32'(r_wpos) < WINDOW_LEN)
    `ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == ST_ACC_MUL)
    `ASSERT_RST(a_div_done_wait, i_clk, i_rst_n, w_div_done |-> r_state == ST_DIV_WAIT)
    `ASSERT_RST(a_no_bias_zero, i_clk, i_rst_n, o_bias.valid && !o_bias.bias_valid |-> out_zero)

endmodule
`default_nettype wire

[test/gsbe_bias_checker.sv]
module gsbe_bias_checker import gsbe_pkg::*; #(
    parameter int WINDOW_LEN = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gsbe_in_if                    i_sample,
    gsbe_out_if                   i_bias,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_biases
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WSUM_W = SMP_W + $clog2(WINDOW_LEN) + 1;
    localparam int SQ_W   = 2 * SMP_W - 1 + $clog2(WINDOW_LEN);
    localparam int ISUM_W = 34;
    localparam int CNT_W  = 17;
    localparam int POS_W  = $clog2(WINDOW_LEN) + 1;
    localparam longint unsigned WIN_LEN = WINDOW_LEN;

    typedef struct {
        logic signed [SMP_W-1:0] gyro  [NUM_AXES];
        logic signed [SMP_W-1:0] accel [NUM_AXES];
    } t_imu_sample;

    typedef struct {
        logic                    valid;
        logic signed [SMP_W-1:0] bias [NUM_AXES];
    } t_bias_result;

    logic [THR_W-1:0]         noise_thr;
    logic [MIN_W-1:0]         min_static;
    logic [POS_W-1:0]         win_pos;
    logic signed [WSUM_W-1:0] accel_sum    [NUM_AXES];
    logic [SQ_W-1:0]          accel_sq_sum [NUM_AXES];
    logic signed [WSUM_W-1:0] gyro_win_sum [NUM_AXES];
    logic signed [ISUM_W-1:0] interval_sum [NUM_AXES];
    logic [CNT_W-1:0]         interval_count;

    t_bias_result expected_biases[$];
    int           errors;
    int           results_seen;
    int           biases_seen;

    function automatic void clear_window();
        win_pos      = '0;
        accel_sum    = '{default: '0};
        accel_sq_sum = '{default: '0};
        gyro_win_sum = '{default: '0};
    endfunction

    function automatic void clear_interval();
        interval_sum   = '{default: '0};
        interval_count = '0;
    endfunction

    // Fold one sample into the window; at the window end run the variance test
    // and, once the static interval is long enough, produce the mean gyro.
    function automatic t_bias_result fold_sample(input t_imu_sample s);
        t_bias_result    r;
        longint unsigned spread;
        longint unsigned limit;
        longint unsigned mag;
        longint          a;
        longint          n;
        r.valid = 1'b0;
        r.bias  = '{default: '0};
        for (int i = 0; i < NUM_AXES; i++) begin
            accel_sum[i]    += s.accel[i];
            accel_sq_sum[i] += SQ_W'(longint'(s.accel[i]) * longint'(s.accel[i]));
            gyro_win_sum[i] += s.gyro[i];
        end
        win_pos++;
        if (win_pos == POS_W'(WINDOW_LEN)) begin
            spread = 0;
            for (int i = 0; i < NUM_AXES; i++) begin
                a      = longint'(accel_sum[i]);
                mag    = (a < 0) ? -a : a;
                spread += WIN_LEN * accel_sq_sum[i] - mag * mag;
            end
            limit = 64'(noise_thr) * WIN_LEN * WIN_LEN;
            if (spread < limit) begin
                for (int i = 0; i < NUM_AXES; i++) begin
                    interval_sum[i] += gyro_win_sum[i];
                end
                interval_count += CNT_W'(WINDOW_LEN);
                if (interval_count > min_static) begin
                    n = longint'(interval_count);
                    for (int i = 0; i < NUM_AXES; i++) begin
                        r.bias[i] = SMP_W'(longint'(interval_sum[i]) / n);
                    end
                    r.valid = 1'b1;
                    clear_interval();
                end
            end else begin
                clear_interval();
            end
            clear_window();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_imu_sample  s;
        t_bias_result want;
        t_bias_result got;
        logic         ok;
        if (!i_rst_n) begin
            noise_thr  = NOISE_THR_RST;
            min_static = MIN_STATIC_RST;
            clear_window();
            clear_interval();
            expected_biases.delete();
            errors       = 0;
            results_seen = 0;
            biases_seen  = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_NOISE_THR:  noise_thr  = i_cfg_data[THR_W-1:0];
                    CFG_MIN_STATIC: min_static = i_cfg_data[MIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_sample.valid && i_sample.ready) begin
                s.gyro[0]  = i_sample.gyro_x;
                s.gyro[1]  = i_sample.gyro_y;
                s.gyro[2]  = i_sample.gyro_z;
                s.accel[0] = i_sample.accel_x;
                s.accel[1] = i_sample.accel_y;
                s.accel[2] = i_sample.accel_z;
                expected_biases.push_back(fold_sample(s));
            end
            if (i_bias.valid && i_bias.ready) begin
                got.valid   = i_bias.bias_valid;
                got.bias[0] = i_bias.bias_x;
                got.bias[1] = i_bias.bias_y;
                got.bias[2] = i_bias.bias_z;
                results_seen++;
                if (expected_biases.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("result %0d arrived with no request outstanding:", results_seen,
                                 " valid=%0b x=%0d y=%0d z=%0d",
                                 got.valid, got.bias[0], got.bias[1], got.bias[2]);
                    end
                end else begin
                    want = expected_biases.pop_front();
                    if (want.valid) begin
                        biases_seen++;
                    end
                    ok = (got.valid === want.valid);
                    for (int i = 0; i < NUM_AXES; i++) begin
                        ok &= (got.bias[i] === want.bias[i]);
                    end
                    if (!ok) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("bias mismatch on result %0d: expected valid=%0b",
                                     results_seen, want.valid,
                                     " x=%0d y=%0d z=%0d, got valid=%0b x=%0d y=%0d z=%0d",
                                     want.bias[0], want.bias[1], want.bias[2],
                                     got.valid, got.bias[0], got.bias[1], got.bias[2]);
                        end
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= expected_biases.size();
        o_results <= results_seen;
        o_biases  <= biases_seen;
    end

endmodule

[test/gyro_static_bias_estimator_tb.sv]
module gyro_static_bias_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gsbe_pkg::*;

    localparam int WINDOW_LEN  = 32;
    localparam int ITEM_TARGET = 1600;
    localparam int LONG_HOLD   = 300;

    typedef logic signed [SMP_W-1:0] t_axes [NUM_AXES];
    typedef enum {WIN_CALM, WIN_NOISY, WIN_SPIKE} t_window_kind;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  cfg_we  = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    gsbe_in_if  sample_ch ();
    gsbe_out_if bias_ch ();

    int bias_errors;
    int bias_pending;
    int bias_results;
    int bias_count;

    int               items_sent   = 0;
    int               burst_left   = 0;
    int               settings_used = 0;
    logic [THR_W-1:0] cur_thr      = NOISE_THR_RST;
    logic             hold_go      = 1'b0;
    logic             hold_done    = 1'b0;

    always #5 clk = ~clk;

    gyro_static_bias_estimator #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .o_bias     (bias_ch)
    );

    gsbe_bias_checker #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_sample   (sample_ch),
        .i_bias     (bias_ch),
        .o_errors   (bias_errors),
        .o_pending  (bias_pending),
        .o_results  (bias_results),
        .o_biases   (bias_count)
    );

    function automatic int jitter(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Jitter amplitude whose variance sits at a given fraction of the threshold.
    function automatic int calm_amp(input logic [THR_W-1:0] thr, input real scale);
        real r;
        r = $sqrt(real'(thr)) * scale;
        return (r > 16000.0) ? 16000 : int'(r);
    endfunction

    task automatic send_item(input t_axes g, input t_axes a);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        burst_left--;
        sample_ch.valid   <= 1'b1;
        sample_ch.gyro_x  <= g[0];
        sample_ch.gyro_y  <= g[1];
        sample_ch.gyro_z  <= g[2];
        sample_ch.accel_x <= a[0];
        sample_ch.accel_y <= a[1];
        sample_ch.accel_z <= a[2];
        do @(posedge clk); while (!sample_ch.ready);
        items_sent++;
    endtask

    // Drop valid and hold until every outstanding request has its result.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (bias_pending != 0);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] min_cnt);
        drain();
        write_reg(CFG_NOISE_THR, thr);
        write_reg(CFG_MIN_STATIC, min_cnt);
        cur_thr = thr[THR_W-1:0];
        settings_used++;
    endtask

    // Fill the rest of the current window. A spike window holds the accel
    // constant except for one step of 32 counts, which lands exactly on a
    // threshold of 31.
    task automatic send_window(input t_window_kind kind, input int amp);
        t_axes       g;
        t_axes       a;
        t_axes       gbase;
        t_axes       abase;
        int          left;
        int          spike_at;
        int          spike_axis;
        int          gspan;
        left       = WINDOW_LEN - (items_sent % WINDOW_LEN);
        spike_at   = $urandom_range(0, left - 1);
        spike_axis = $urandom_range(0, NUM_AXES - 1);
        gspan      = $urandom_range(0, 64);
        for (int i = 0; i < NUM_AXES; i++) begin
            gbase[i] = ($urandom_range(0, 1) != 0) ? SMP_W'($urandom)
                                                   : SMP_W'(int'($urandom_range(0, 600)) - 300);
            abase[i] = (kind == WIN_SPIKE)
                       ? SMP_W'(int'($urandom_range(0, 65535 - 32)) - 32768)
                       : SMP_W'($urandom);
        end
        for (int k = 0; k < left; k++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                g[i] = SMP_W'(gbase[i] + jitter(gspan));
                case (kind)
                    WIN_NOISY: a[i] = SMP_W'($urandom);
                    WIN_SPIKE: a[i] = (k == spike_at && i == spike_axis) ? abase[i] + 16'sd32
                                                                         : abase[i];
                    default:   a[i] = SMP_W'(abase[i] + jitter(amp));
                endcase
            end
            send_item(g, a);
        end
    endtask

    // Receiver: stretches of always-ready, random, every-fourth and mostly-ready,
    // plus one long hold-off once the stimulus asks for it.
    initial begin
        int seg_len;
        int pattern;
        bias_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_go && !hold_done) begin
                bias_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                pattern = $urandom_range(0, 3);
                seg_len = $urandom_range(8, 80);
                for (int k = 0; k < seg_len; k++) begin
                    case (pattern)
                        0:       bias_ch.ready <= 1'b1;
                        1:       bias_ch.ready <= 1'($urandom_range(0, 1));
                        2:       bias_ch.ready <= (k % 4 == 3);
                        default: bias_ch.ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin
        logic signed [SMP_W-1:0] extremes [8];
        t_axes                   g;
        t_axes                   a;
        logic [CFG_DATA_W-1:0]   thr_pick;
        logic [CFG_DATA_W-1:0]   min_pick;
        int                      pick;
        sample_ch.valid   <= 1'b0;
        sample_ch.gyro_x  <= '0;
        sample_ch.gyro_y  <= '0;
        sample_ch.gyro_z  <= '0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        extremes = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                     16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFE};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes at the reset settings
        for (int k = 0; k < 24; k++) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                g[i] = extremes[(k + i) % 8];
                a[i] = extremes[(3 * k + 2 * i + 1) % 8];
            end
            send_item(g, a);
        end
        send_window(WIN_NOISY, 0);

        // quiet run at reset settings; the output side stalls for a long stretch
        hold_go = 1'b1;
        repeat (5) send_window(WIN_CALM, calm_amp(cur_thr, 0.5));

        // zero threshold: even a flat window is not quiet
        set_config(32'd0, 32'd100);
        repeat (4) send_window(WIN_CALM, 0);

        // widest threshold and zero minimum: every window gives a bias
        set_config('1, 32'd0);
        repeat (3) send_window(WIN_NOISY, 0);
        repeat (2) send_window(WIN_CALM, 2000);

        // spread exactly at the limit, then just under it
        set_config(32'd31, 32'd0);
        repeat (2) send_window(WIN_SPIKE, 0);
        set_config(32'd32, 32'd0);
        repeat (2) send_window(WIN_SPIKE, 0);

        // upper bits of the minimum are dropped, leaving 64
        set_config(32'd1000, 32'hABCD_0040);
        repeat (6) send_window(WIN_CALM, calm_amp(cur_thr, 0.5));
        set_config(32'd1000, WINDOW_LEN);
        repeat (4) send_window(WIN_CALM, calm_amp(cur_thr, 0.5));
        set_config(32'd1000, WINDOW_LEN - 1);
        repeat (2) send_window(WIN_CALM, calm_amp(cur_thr, 0.5));
        set_config(32'd2000, 32'hFFFF);
        repeat (3) send_window(WIN_CALM, calm_amp(cur_thr, 0.5));

        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       thr_pick = '0;
                1:       thr_pick = '1;
                2:       thr_pick = $urandom_range(1, 64);
                3:       thr_pick = $urandom;
                default: thr_pick = $urandom_range(100, 20000);
            endcase
            case ($urandom_range(0, 7))
                0:       min_pick = '0;
                1:       min_pick = 32'hFFFF;
                2:       min_pick = $urandom;
                3:       min_pick = WINDOW_LEN - 1 + $urandom_range(0, 2);
                default: min_pick = $urandom_range(1, 200);
            endcase
            set_config(thr_pick, min_pick);
            repeat ($urandom_range(2, 8)) begin
                pick = $urandom_range(0, 19);
                if (pick < 11) begin
                    send_window(WIN_CALM, calm_amp(cur_thr, 0.5));
                end else if (pick < 14) begin
                    send_window(WIN_CALM, calm_amp(cur_thr, 1.0));
                end else if (pick < 17) begin
                    send_window(WIN_NOISY, 0);
                end else begin
                    send_window(WIN_SPIKE, 0);
                end
            end
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Ran %0d samples through %0d register settings with a %0d-cycle output stall.",
                 items_sent, settings_used, LONG_HOLD);
        $display("Checked %0d results, %0d of them carrying a bias estimate.",
                 bias_results, bias_count);
        if (bias_errors == 0 && bias_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
